/* rtl/sorted_value_list_defines.svh */
// assertion macros for the sorted value list
`ifndef SORTED_VALUE_LIST_DEFINES_SVH
`define SORTED_VALUE_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SVL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/svl_pkg.sv */
package svl_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
  } svl_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } svl_out_t;

  // result of the shared comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } svl_cmp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_DUMP
  } svl_state_t;

endpackage

/* rtl/svl_mem.sv */
module svl_mem import svl_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata_r
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/svl_cmp.sv */
module svl_cmp import svl_pkg::*; (
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output svl_cmp_t                  res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

/* rtl/sorted_value_list.sv */
// channel   ports                         transfer when
// ------    ----------------------------  ------------------------------
// input     start, busy, in_item          start high and busy low
// result    out_strobe, out_item          out_strobe high (one cycle each)
//
// one shared comparator walks the stored entries one per cycle under the
// sequencer; the entry memory has one write and one registered read port
// insert: scan to find the place, shift the entries above it up, then write
// delete: scan to find the match, then shift the entries after it down
// dump: one result per cycle; full, empty or action 3 end in the accept
// cycle; each result is registered and shows in the cycle after it is made;
// results cannot be stalled, and a new transfer may start while the last shows
// synchronous active-low reset empties the list; no clearing pass needed
`include "sorted_value_list_defines.svh"

module sorted_value_list import svl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  svl_in_t  in_item,
  output logic     out_strobe,
  output svl_out_t out_item
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // sequencer state
  svl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;      // entry under the comparator
  logic [CNT_W-1:0] pos_r, pos_nxt;      // insert position
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // stored entries
  logic [ACTION_W-1:0]       act_r;
  logic signed [VALUE_W-1:0] val_r;

  logic [CNT_W-1:0] idx_inc, idx_dec, cnt_dec;
  logic             accept;
  logic             full;

  // memory and comparator hookup
  logic                      we;
  logic [CNT_W-1:0]          waddr_full;
  logic signed [VALUE_W-1:0] wdata;
  logic signed [VALUE_W-1:0] rdata_r;
  svl_cmp_t                  cmp;

  // result being made this cycle
  logic                      emit_v;
  logic signed [VALUE_W-1:0] emit_val;
  logic [STATUS_W-1:0]       emit_st;
  logic                      emit_last;
  logic [EXT_W-1:0]          cnt_ext;

  logic     out_strobe_r;
  svl_out_t out_item_r;

  assign accept  = start && (state_r == S_IDLE);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign cnt_dec = cnt_r - CNT_W'(1);

  // read address runs one step ahead so rdata_r always holds entry idx_r
  svl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr_full[AW-1:0]),
    .wdata   (wdata),
    .raddr   (idx_nxt[AW-1:0]),
    .rdata_r (rdata_r)
  );

  // shared compare: stored entry against the operand
  svl_cmp u_cmp (
    .a   (rdata_r),
    .b   (val_r),
    .res (cmp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.action)
            ACT_INSERT: state_nxt = (cnt_r == CNT_W'(DEPTH)) ? S_IDLE : S_SCAN;
            ACT_DELETE: state_nxt = S_SCAN;
            ACT_DUMP:   state_nxt = (cnt_r == '0) ? S_IDLE : S_DUMP;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (act_r == ACT_INSERT) begin
          priority if (idx_r == cnt_r) begin
            state_nxt = S_PUT;
          end else if (!cmp.lt) begin
            state_nxt = S_SHIFT_UP;
          end
        end else begin
          priority if (idx_r == cnt_r) begin
            state_nxt = S_IDLE;
          end else if (cmp.eq) begin
            state_nxt = (idx_inc == cnt_r) ? S_IDLE : S_SHIFT_DN;
          end
        end
      end
      S_SHIFT_UP: begin
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end
      end
      S_SHIFT_DN: begin
        if (idx_r == cnt_dec) begin
          state_nxt = S_IDLE;
        end
      end
      S_PUT: state_nxt = S_IDLE;
      S_DUMP: begin
        if (idx_r == cnt_dec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    we         = 1'b0;
    waddr_full = idx_inc;
    wdata      = rdata_r;
    emit_v     = 1'b0;
    emit_val   = val_r;
    emit_st    = ST_OK;
    emit_last  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt  = '0;
          emit_val = in_item.value;
          unique case (in_item.action)
            ACT_INSERT: begin
              // full list: flag it and leave the entries alone
              if (full) begin
                emit_v  = 1'b1;
                emit_st = ST_FULL;
              end
            end
            ACT_DUMP: begin
              if (cnt_r == '0) begin
                emit_v   = 1'b1;
                emit_val = '0;
                emit_st  = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (act_r == ACT_INSERT) begin
          // first entry not smaller than the value marks the slot
          priority if (idx_r == cnt_r) begin
            pos_nxt = idx_r;
          end else if (!cmp.lt) begin
            pos_nxt = idx_r;
            idx_nxt = cnt_dec;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          priority if (idx_r == cnt_r) begin
            // ran off the end, empty list included
            emit_v  = 1'b1;
            emit_st = ST_NOT_FOUND;
          end else if (cmp.eq) begin
            if (idx_inc == cnt_r) begin
              // match in the tail slot: just drop it
              cnt_nxt = cnt_dec;
              emit_v  = 1'b1;
            end else begin
              idx_nxt = idx_inc;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      S_SHIFT_UP: begin
        // move entry idx up by one, walking down toward the slot
        we         = 1'b1;
        waddr_full = idx_inc;
        if (idx_r != pos_r) begin
          idx_nxt = idx_dec;
        end
      end
      S_SHIFT_DN: begin
        // move entry idx down by one, closing the gap
        we         = 1'b1;
        waddr_full = idx_dec;
        if (idx_r == cnt_dec) begin
          cnt_nxt = cnt_dec;
          emit_v  = 1'b1;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr_full = pos_r;
        wdata      = val_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
        emit_v     = 1'b1;
      end
      S_DUMP: begin
        emit_v    = 1'b1;
        emit_val  = rdata_r;
        emit_last = (idx_r == cnt_dec);
        if (idx_r != cnt_dec) begin
          idx_nxt = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // count field is the low bits of the entry count
  assign cnt_ext = EXT_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      pos_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      pos_r        <= pos_nxt;
      out_strobe_r <= emit_v;
    end
  end

  // operand capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_item.action;
      val_r <= in_item.value;
    end
    if (emit_v) begin
      out_item_r.item_value <= emit_val;
      out_item_r.status     <= emit_st;
      out_item_r.count      <= cnt_ext[COUNT_W-1:0];
      out_item_r.last       <= emit_last;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `SVL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "entry count above depth")
  `SVL_ASSERT_NOW(a_last_idle, out_strobe_r && out_item_r.last, state_r == S_IDLE,
    "final result shown while sequencer still busy")
  `SVL_ASSERT_NOW(a_mid_busy, out_strobe_r && !out_item_r.last, state_r == S_DUMP,
    "non-final result outside a dump")
  `SVL_ASSERT_NEXT(a_cnt_result, cnt_nxt != cnt_r, out_strobe_r && out_item_r.status == ST_OK,
    "entry count changed without a good result")

endmodule

/* tb/svl_list_checker.sv */
module svl_list_checker import svl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  svl_in_t  in_item,
  input  logic     out_strobe,
  input  svl_out_t out_item,
  output int       fail_count,
  output int       results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] list_vals [DEPTH];
  int                        list_len;
  svl_out_t                  pending_results [$];
  int                        errs;

  initial begin
    fail_count      = 0;
    results_pending = 0;
    list_len        = 0;
    errs            = 0;
  end

  // sorted list update for one accepted command, queues the results it causes
  task automatic apply_list_op(input svl_in_t op);
    int       pos;
    svl_out_t r;
    r = '0;
    r.item_value = op.value;
    r.last = 1'b1;
    case (op.action)
      ACT_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = list_len;
          for (int i = 0; i < list_len; i++) begin
            if (!($signed(list_vals[i]) < $signed(op.value))) begin
              pos = i;
              break;
            end
          end
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = op.value;
          list_len++;
          r.status = ST_OK;
        end
        r.count = COUNT_W'(list_len);
        pending_results.push_back(r);
      end
      ACT_DELETE: begin
        pos = list_len;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == op.value) begin
            pos = i;
            break;
          end
        end
        if (pos == list_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          r.status = ST_OK;
        end
        r.count = COUNT_W'(list_len);
        pending_results.push_back(r);
      end
      ACT_DUMP: begin
        if (list_len == 0) begin
          r.item_value = '0;
          r.status = ST_EMPTY;
          r.count = '0;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.item_value = list_vals[i];
            r.status = ST_OK;
            r.count = COUNT_W'(list_len);
            r.last = (i == list_len - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;  // undefined action: no result, list untouched
    endcase
  endtask

  always @(posedge clk) begin
    svl_out_t want;
    if (!rst_n) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      // results first: a new command never causes a result in its own cycle
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending, item_value %0d", out_item.item_value);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.item_value !== want.item_value) begin
            $error("item_value: expected %0d, actual %0d", want.item_value,
                   out_item.item_value);
            errs++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            errs++;
          end
          if (out_item.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_item.count);
            errs++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_item.last);
            errs++;
          end
        end
      end
      if (start && !busy) apply_list_op(in_item);
    end
    results_pending <= pending_results.size();
    fail_count      <= errs;
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import svl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              LIST_DEPTH  = 16;
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;  // no result, no change
  localparam int              STALL_LIMIT = 4000;  // cycles with no transfer at all
  localparam int              TAIL_CYCLES = 40;    // settle time once nothing is pending
  localparam int              ITEMS_PER_PHASE = 100;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  svl_in_t  in_item = '0;
  logic     out_strobe;
  svl_out_t out_item;
  int       fail_count;
  int       results_pending;

  int       idle_pct = 0;
  int       idle_cycles = 0;

  // recently inserted values, so deletes and duplicate inserts hit stored entries
  logic signed [VALUE_W-1:0] recent_vals [16];
  int                        recent_n = 0;
  int                        recent_wr = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_value_list #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  svl_list_checker #(.DEPTH(LIST_DEPTH)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_strobe      (out_strobe),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // watchdog: any command or result transfer restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one command transfer; start stays high into the next command unless
  // the sender decides to idle for a few cycles first
  task automatic send_cmd(input logic [ACTION_W-1:0] act,
                          input logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{action: act, value: val};
    do @(posedge clk); while (busy);
    if (act == ACT_INSERT) begin
      recent_vals[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 16;
      if (recent_n < 16) recent_n++;
    end
  endtask

  // hold off until the list has answered everything sent so far
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);  // covers an undefined action still in flight
  endtask

  initial begin
    logic signed [VALUE_W-1:0] fill_vals [16];
    logic [ACTION_W-1:0]       act;
    logic signed [VALUE_W-1:0] val;
    int                        sent;
    int                        r;
    int                        k;
    bit                        fill_mode;

    // extremes, sign boundaries, duplicates of 0, max and min
    fill_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd0,
                  -32'sd2, 32'sd2, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd100, -32'sd100,
                  32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7, -32'sd7};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: operations on an empty list
    send_cmd(ACT_DUMP, 32'sd0);            // empty status
    send_cmd(ACT_DELETE, 32'sd5);          // delete on empty list
    send_cmd(ACT_UNDEF, 32'sh1234_5678);   // ignored
    // fill to capacity, then one more insert to hit the full status
    foreach (fill_vals[i]) send_cmd(ACT_INSERT, fill_vals[i]);
    send_cmd(ACT_INSERT, 32'sd42);
    send_cmd(ACT_DUMP, 32'sd0);            // longest dump, sixteen results
    drain_results();                       // sender waits for every result once
    send_cmd(ACT_DELETE, 32'sd999);        // miss on a non-empty list
    send_cmd(ACT_DELETE, 32'sd0);          // first of two equal entries
    send_cmd(ACT_DELETE, 32'sh8000_0000);
    send_cmd(ACT_DELETE, 32'sh7fff_ffff);
    send_cmd(ACT_DUMP, 32'sd0);

    // random: sender idles 31%, then 66%, then never; the mix swings between
    // filling and emptying so both the full and the empty list come up often
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
      sent = 0;
      fill_mode = 1'b1;
      while (sent < ITEMS_PER_PHASE) begin
        if (sent % 30 == 29) fill_mode = ~fill_mode;
        r = $urandom_range(99);
        if (r < 4)                     act = ACT_UNDEF;
        else if (r < (fill_mode ? 60 : 30)) act = ACT_INSERT;
        else if (r < (fill_mode ? 85 : 82)) act = ACT_DELETE;
        else                           act = ACT_DUMP;

        k = $urandom_range(9);
        if (k < 4 && recent_n > 0) val = recent_vals[$urandom_range(recent_n - 1)];
        else if (k < 6)            val = $signed($urandom_range(16)) - 32'sd8;
        else if (k == 6) begin
          case ($urandom_range(3))
            0:       val = 32'sh8000_0000;
            1:       val = 32'sh7fff_ffff;
            2:       val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end else                   val = $urandom;

        send_cmd(act, val);
        if (act != ACT_UNDEF) sent++;
        // occasional full stop so commands also start on a quiet block
        if (act != ACT_UNDEF && sent % 50 == 0) drain_results();
      end
    end

    // wind down: nothing more to send, let the last results arrive
    start <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
